/* rtl/nnis_pkg.sv */
// Shared definitions for the nearest-neighbour image scaler.
// Holds parameter defaults, register indexes, word codes and the control group
// type. It depends on nothing else.
package nnis_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_DIM_DEF    = 256;
	localparam int PIXEL_BITS_DEF = 16;

	// Configuration register indexes
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

	// Command carried on the input tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Status carried on the output tuser
	localparam logic ST_OK           = 1'b0;
	localparam logic ST_OUT_OF_RANGE = 1'b1;

	// Control group that travels with each word down the pipeline
	typedef struct packed {
		logic rd;     // word is a read of a destination pixel
		logic oor;    // destination coordinate outside the configured size
		logic wr_ok;  // write lies inside the source image
	} ctrl_t;

endpackage

/* rtl/nearest_neighbor_image_scaler.sv */
// Nearest-neighbour image scaler, top level.
// The slave stream carries commands: tuser selects a write of a source pixel or
// a read of a destination pixel, tdata holds row, column and pixel value.
// A write stores the pixel when it lies inside the source size, else it is
// dropped; it never produces an output word. A read maps the destination
// coordinate back with row*src_height/dst_height and col*src_width/dst_width
// and returns the stored pixel, or status out-of-range with value 0.
// Sizes are set through the write-only register port, by the user only while
// no word is in flight; the block does not enforce this. Reads pass the input,
// product, divider, memory and output stages; the divider sets the depth and
// resolves one quotient bit per stage. Throughput is one word per cycle while
// the master side is ready; when it stalls, words collect in the stages and
// tready falls only once every stage is full; nothing is lost or repeated.
// Reset clears all valid bits and sets every size to MAX_DIM. The frame store is
// not cleared: a pixel must be written before it is read.
// Depends on nnis_pkg, nnis_cfg, nnis_map_pipe and nnis_frame_store.
module nearest_neighbor_image_scaler #(
	parameter int MAX_DIM    = nnis_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = nnis_pkg::PIXEL_BITS_DEF,
	localparam int CW = $clog2(MAX_DIM),
	localparam int SW = CW + 1,
	localparam int IW = ((2 * CW + PIXEL_BITS + 7) / 8) * 8,
	localparam int OW = ((PIXEL_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [IW-1:0]                  s_tdata,   // row, col, pixel_in
	input  logic                           s_tuser,   // cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [OW-1:0]                  m_tdata,   // pixel_out
	output logic                           m_tuser,   // status
	input  logic                           cfg_we,
	input  logic [nnis_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [SW-1:0]                  cfg_data
);
	import nnis_pkg::*;

	logic [SW-1:0]         src_w;
	logic [SW-1:0]         src_h;
	logic [SW-1:0]         dst_w;
	logic [SW-1:0]         dst_h;
	logic                  in_rd;
	logic [CW-1:0]         in_row;
	logic [CW-1:0]         in_col;
	logic [PIXEL_BITS-1:0] in_pix;
	logic                  map_valid;
	logic                  map_ready;
	ctrl_t                 map_ctrl;
	logic [2*CW-1:0]       map_addr;
	logic [PIXEL_BITS-1:0] map_pix;
	logic [PIXEL_BITS-1:0] out_pixel;

	// Unpack the command word.
	assign in_rd  = (s_tuser == CMD_READ);
	assign in_row = s_tdata[CW-1:0];
	assign in_col = s_tdata[2*CW-1:CW];
	assign in_pix = s_tdata[2*CW+PIXEL_BITS-1:2*CW];

	nnis_cfg #(
		.MAX_DIM (MAX_DIM)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_w     (src_w),
		.src_h     (src_h),
		.dst_w     (dst_w),
		.dst_h     (dst_h)
	);

	nnis_map_pipe #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_rd     (in_rd),
		.in_row    (in_row),
		.in_col    (in_col),
		.in_pix    (in_pix),
		.src_w     (src_w),
		.src_h     (src_h),
		.dst_w     (dst_w),
		.dst_h     (dst_h),
		.out_valid (map_valid),
		.out_ready (map_ready),
		.out_ctrl  (map_ctrl),
		.out_addr  (map_addr),
		.out_pix   (map_pix)
	);

	nnis_frame_store #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (map_valid),
		.in_ready   (map_ready),
		.in_ctrl    (map_ctrl),
		.in_addr    (map_addr),
		.in_pix     (map_pix),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_pixel  (out_pixel),
		.out_status (m_tuser)
	);

	// Pad the result word to whole bytes.
	assign m_tdata = OW'(out_pixel);

endmodule

/* rtl/nnis_cfg.sv */
// Size registers of the nearest-neighbour image scaler.
// Stores the four image sizes already limited to the range 1 to MAX_DIM.
// Depends on nnis_pkg.
module nnis_cfg #(
	parameter int MAX_DIM = nnis_pkg::MAX_DIM_DEF,
	localparam int CW = $clog2(MAX_DIM),
	localparam int SW = CW + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nnis_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [SW-1:0]                  cfg_data,
	output logic [SW-1:0]                  src_w,
	output logic [SW-1:0]                  src_h,
	output logic [SW-1:0]                  dst_w,
	output logic [SW-1:0]                  dst_h
);
	import nnis_pkg::*;

	logic [SW-1:0] src_w_q;
	logic [SW-1:0] src_h_q;
	logic [SW-1:0] dst_w_q;
	logic [SW-1:0] dst_h_q;
	logic [SW-1:0] eff_size;

	// A size of zero behaves as one; anything above the frame store behaves as its edge.
	always_comb begin
		if (cfg_data == '0) begin
			eff_size = SW'(1);
		end else if (cfg_data > SW'(MAX_DIM)) begin
			eff_size = SW'(MAX_DIM);
		end else begin
			eff_size = cfg_data;
		end
	end

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SW'(MAX_DIM);
			src_h_q <= SW'(MAX_DIM);
			dst_w_q <= SW'(MAX_DIM);
			dst_h_q <= SW'(MAX_DIM);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:  src_w_q <= eff_size;
				REG_SRC_HEIGHT: src_h_q <= eff_size;
				REG_DST_WIDTH:  dst_w_q <= eff_size;
				REG_DST_HEIGHT: dst_h_q <= eff_size;
				default: ;
			endcase
		end
	end

	assign src_w = src_w_q;
	assign src_h = src_h_q;
	assign dst_w = dst_w_q;
	assign dst_h = dst_h_q;

endmodule

/* rtl/nnis_map_pipe.sv */
// Coordinate mapping pipeline of the nearest-neighbour image scaler.
// Range checks, the row and column products and a restoring divider with one
// quotient bit per stage; ends in the frame store address. Depends on nnis_pkg.
module nnis_map_pipe #(
	parameter int MAX_DIM    = nnis_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = nnis_pkg::PIXEL_BITS_DEF,
	localparam int CW = $clog2(MAX_DIM),
	localparam int SW = CW + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_rd,
	input  logic [CW-1:0]         in_row,
	input  logic [CW-1:0]         in_col,
	input  logic [PIXEL_BITS-1:0] in_pix,
	input  logic [SW-1:0]         src_w,
	input  logic [SW-1:0]         src_h,
	input  logic [SW-1:0]         dst_w,
	input  logic [SW-1:0]         dst_h,
	output logic                  out_valid,
	input  logic                  out_ready,
	output nnis_pkg::ctrl_t       out_ctrl,
	output logic [2*CW-1:0]       out_addr,
	output logic [PIXEL_BITS-1:0] out_pix
);
	import nnis_pkg::*;

	localparam int RW = 2 * CW + 1;  // width of a product and of a remainder
	localparam int NS = CW + 2;      // input stage, product stage, one stage per quotient bit

	typedef struct packed {
		ctrl_t                 ctrl;
		logic [CW-1:0]         row;
		logic [CW-1:0]         col;
		logic [PIXEL_BITS-1:0] pix;
		logic [RW-1:0]         rem_r;
		logic [RW-1:0]         rem_c;
		logic [CW-1:0]         quo_r;
		logic [CW-1:0]         quo_c;
	} stage_t;

	stage_t        pipe_s [NS];
	stage_t        nxt    [NS];
	logic [NS-1:0] vld_s;
	logic [NS:0]   adv;
	logic [SW-1:0] last_r;
	logic [SW-1:0] last_c;
	logic [CW-1:0] map_r;
	logic [CW-1:0] map_c;

	// Input stage: capture the word and decide its range flags.
	always_comb begin
		nxt[0]              = '0;
		nxt[0].ctrl.rd      = in_rd;
		nxt[0].ctrl.oor     = (SW'(in_row) >= dst_h) || (SW'(in_col) >= dst_w);
		nxt[0].ctrl.wr_ok   = (SW'(in_row) < src_h) && (SW'(in_col) < src_w);
		nxt[0].row          = in_row;
		nxt[0].col          = in_col;
		nxt[0].pix          = in_pix;
	end

	// Product stage: row times source height and column times source width.
	always_comb begin
		nxt[1]       = pipe_s[0];
		nxt[1].rem_r = RW'(pipe_s[0].row) * RW'(src_h);
		nxt[1].rem_c = RW'(pipe_s[0].col) * RW'(src_w);
	end

	// Divider stages, most significant quotient bit first.
	for (genvar k = 2; k < NS; k++) begin : g_div
		localparam int BIT = CW + 1 - k;
		logic [RW-1:0] dsh_r;
		logic [RW-1:0] dsh_c;

		always_comb begin
			dsh_r  = RW'(dst_h) << BIT;
			dsh_c  = RW'(dst_w) << BIT;
			nxt[k] = pipe_s[k-1];
			if (pipe_s[k-1].rem_r >= dsh_r) begin
				nxt[k].rem_r      = pipe_s[k-1].rem_r - dsh_r;
				nxt[k].quo_r[BIT] = 1'b1;
			end
			if (pipe_s[k-1].rem_c >= dsh_c) begin
				nxt[k].rem_c      = pipe_s[k-1].rem_c - dsh_c;
				nxt[k].quo_c[BIT] = 1'b1;
			end
		end
	end

	// A stage loads when it is empty or its word moves on.
	assign adv[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_adv
		assign adv[k] = !vld_s[k] || adv[k+1];
	end
	assign in_ready = adv[0];

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (adv[k]) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	// Clamp to the last source row and column, then form the store address.
	always_comb begin
		last_r = src_h - SW'(1);
		last_c = src_w - SW'(1);
		map_r  = (SW'(pipe_s[NS-1].quo_r) > last_r) ? last_r[CW-1:0] : pipe_s[NS-1].quo_r;
		map_c  = (SW'(pipe_s[NS-1].quo_c) > last_c) ? last_c[CW-1:0] : pipe_s[NS-1].quo_c;
		if (pipe_s[NS-1].ctrl.rd) begin
			out_addr = {map_r, map_c};
		end else begin
			out_addr = {pipe_s[NS-1].row, pipe_s[NS-1].col};
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_ctrl  = pipe_s[NS-1].ctrl;
	assign out_pix   = pipe_s[NS-1].pix;

	// An accepted word always lands in the input stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[0])
		else $error("accepted word missing from input stage");

	// A stalled last stage keeps its word unchanged.
	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS-1] && !out_ready |=> vld_s[NS-1] && $stable(pipe_s[NS-1]))
		else $error("stalled word lost or altered");

	// An in-range read maps inside the source image without clamping.
	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS-1] && pipe_s[NS-1].ctrl.rd && !pipe_s[NS-1].ctrl.oor
		|-> (SW'(pipe_s[NS-1].quo_r) < src_h) && (SW'(pipe_s[NS-1].quo_c) < src_w))
		else $error("mapped coordinate beyond source image");

endmodule

/* rtl/nnis_frame_store.sv */
// Frame store and output register of the nearest-neighbour image scaler.
// Writes and reads share one memory stage, so words keep their stream order.
// Depends on nnis_pkg.
module nnis_frame_store #(
	parameter int MAX_DIM    = nnis_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = nnis_pkg::PIXEL_BITS_DEF,
	localparam int CW = $clog2(MAX_DIM)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  nnis_pkg::ctrl_t       in_ctrl,
	input  logic [2*CW-1:0]       in_addr,
	input  logic [PIXEL_BITS-1:0] in_pix,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIXEL_BITS-1:0] out_pixel,
	output logic                  out_status
);
	import nnis_pkg::*;

	localparam int DEPTH = 2 ** (2 * CW);

	logic [PIXEL_BITS-1:0] frame_mem_q [DEPTH];
	logic                  vld_s1;
	ctrl_t                 ctrl_s1;
	logic [PIXEL_BITS-1:0] rdata_s1;
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] pixel_q;
	logic                  status_q;
	logic                  ld_o;
	logic                  ld_m;

	assign ld_o     = !out_valid_q || out_ready;
	assign ld_m     = !vld_s1 || ld_o;
	assign in_ready = ld_m;

	// Memory stage: one write or one registered read per word.
	always_ff @(posedge clk) begin
		if (ld_m) begin
			ctrl_s1 <= in_ctrl;
			if (in_valid) begin
				if (in_ctrl.rd) begin
					rdata_s1 <= frame_mem_q[in_addr];
				end else if (in_ctrl.wr_ok) begin
					frame_mem_q[in_addr] <= in_pix;
				end
			end
		end
	end

	// Valid bits of the memory stage and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_m) begin
				vld_s1 <= in_valid;
			end
			if (ld_o) begin
				out_valid_q <= vld_s1 && ctrl_s1.rd;
			end
		end
	end

	// Result word; writes are dropped here and never reach the output.
	always_ff @(posedge clk) begin
		if (ld_o && vld_s1) begin
			pixel_q  <= ctrl_s1.oor ? '0 : rdata_s1;
			status_q <= ctrl_s1.oor ? ST_OUT_OF_RANGE : ST_OK;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_pixel  = pixel_q;
	assign out_status = status_q;

	// A write leaving the memory stage gives no result word.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ld_o && vld_s1 && !ctrl_s1.rd |=> !out_valid_q)
		else $error("write produced a result word");

	// Back-pressure upstream only when both local stages are full.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1 && out_valid_q)
		else $error("memory stage refused a word while not full");

	// A word taken into the memory stage is held there.
	a_mem_lands: assert property (@(posedge clk) disable iff (!arst_n)
		ld_m && in_valid |=> vld_s1)
		else $error("word lost entering memory stage");

endmodule
